FILE: sv/bmtws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmtws_pkg
// shared types, widths and codes for the order book max tracker
// ----------------------------------------------------------------------------
package bmtws_pkg;

    localparam int TIME_W  = 48;
    localparam int KEY_W   = 32;
    localparam int PRICE_W = 32;
    localparam int SUM_W   = 64;

    // request command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_ERASE  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_DUP  = 2'd1,
        STATUS_MISS = 2'd2,
        STATUS_FULL = 2'd3
    } status_t;

    // one book entry as held by a cell
    typedef struct packed {
        logic               valid;
        logic [KEY_W-1:0]   key;
        logic [PRICE_W-1:0] price;
    } entry_t;

    localparam entry_t ENTRY_NONE = '0;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic cmp;  // capture key match and price order flags
        logic ins;  // sorted insert of the request order
        logic del;  // remove matched entry and close the gap
    } cell_ctrl_t;

endpackage

FILE: sv/bmtws_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmtws_cell
// one slot of the price-sorted order chain
// ----------------------------------------------------------------------------
module bmtws_cell
    import bmtws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctrl_t         ctrl,
    input  logic [KEY_W-1:0]   req_key,
    input  logic [PRICE_W-1:0] req_price,
    input  entry_t             prev_entry,
    input  entry_t             next_entry,
    input  logic               prev_keep,
    input  logic               prev_gone,
    output entry_t             entry,
    output logic               keep,
    output logic               match,
    output logic               gone
);

    logic               valid_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [PRICE_W-1:0] price_reg;
    logic               keep_reg;
    logic               match_reg;
    entry_t             entry_next;

    assign entry = '{valid: valid_reg, key: key_reg, price: price_reg};
    assign keep  = keep_reg;
    assign match = match_reg;
    assign gone  = prev_gone | match_reg;

    always_comb
    begin
        entry_next = entry;
        if (ctrl.ins)
        begin
            if (!keep_reg)
            begin
                // slot right after the last higher-or-equal price takes the new order
                if (prev_keep)
                    entry_next = '{valid: 1'b1, key: req_key, price: req_price};
                else
                    entry_next = prev_entry;
            end
        end
        else if (ctrl.del)
        begin
            if (gone)
                entry_next = next_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            keep_reg  <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= entry_next.valid;
            if (ctrl.cmp)
            begin
                keep_reg  <= valid_reg && (price_reg >= req_price);
                match_reg <= valid_reg && (key_reg == req_key);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= entry_next.key;
        price_reg <= entry_next.price;
    end

endmodule

FILE: sv/bmtws_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmtws_mul
// two-stage duration times price product, saturated to 64 bits
// ----------------------------------------------------------------------------
module bmtws_mul
    import bmtws_pkg::*;
(
    input  logic               clk,
    input  logic [TIME_W-1:0]  dur,
    input  logic [PRICE_W-1:0] price,
    output logic [SUM_W-1:0]   prod
);

    localparam int LO_W = 32;
    localparam int HI_W = TIME_W - LO_W;

    logic [LO_W+PRICE_W-1:0] lo_reg;
    logic [HI_W+PRICE_W-1:0] hi_reg;
    logic [SUM_W-1:0]        prod_reg;
    logic [SUM_W:0]          sum_wide;
    logic [SUM_W-1:0]        prod_next;

    assign prod = prod_reg;

    // partial products of the low and high duration parts
    always_ff @(posedge clk)
    begin
        lo_reg <= (LO_W+PRICE_W)'(dur[LO_W-1:0]) * (LO_W+PRICE_W)'(price);
        hi_reg <= (HI_W+PRICE_W)'(dur[TIME_W-1:LO_W]) * (HI_W+PRICE_W)'(price);
    end

    always_comb
    begin
        sum_wide = {1'b0, hi_reg[SUM_W-LO_W-1:0], {LO_W{1'b0}}} + {1'b0, lo_reg};
        if ((hi_reg[HI_W+PRICE_W-1:SUM_W-LO_W] != '0) || sum_wide[SUM_W])
            prod_next = '1;
        else
            prod_next = sum_wide[SUM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

FILE: sv/book_max_time_weighted_sum.sv
`timescale 1ns / 1ps
// a request accepted in idle passes through the match, decide, multiply and
// accumulate states before its result strobe; busy stays high from acceptance until
//   the result cycle, and no new request is taken while busy
// the receiver cannot stall: done is high for exactly one cycle per request
// reset (rst_n low, async) empties the book and clears both sums and the last
//   change time; no clearing pass is needed
// ----------------------------------------------------------------------------
// book_max_time_weighted_sum
// order book kept as a price-sorted chain of cells, with time-weighted sums
// ----------------------------------------------------------------------------
module book_max_time_weighted_sum
    import bmtws_pkg::*;
#(
    parameter int BOOK_DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cmd,
    input  logic [TIME_W-1:0]  timestamp_ms,
    input  logic [KEY_W-1:0]   order_id,
    input  logic [PRICE_W-1:0] order_price,
    output logic               done,
    output logic [1:0]         status,
    output logic [SUM_W-1:0]   weighted_sum,
    output logic [TIME_W-1:0]  time_sum,
    output logic [PRICE_W-1:0] best_price,
    output logic               book_empty
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_DECIDE,
        S_MUL,
        S_ACC
    } state_t;

    state_t              state_reg;
    logic                done_reg;
    status_t             status_reg;
    logic                acc_reg;
    logic                set_last_reg;
    logic [TIME_W-1:0]   last_reg;
    logic [SUM_W-1:0]    wsum_reg;
    logic [TIME_W-1:0]   tsum_reg;

    // request payload, captured at acceptance
    logic                cmd_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [PRICE_W-1:0]  price_reg;
    logic [TIME_W-1:0]   dur_reg;

    // cell chain
    entry_t              cell_q [BOOK_DEPTH];
    logic [BOOK_DEPTH-1:0] keep_v;
    logic [BOOK_DEPTH-1:0] match_v;
    logic [BOOK_DEPTH-1:0] gone_v;
    cell_ctrl_t          ctrl;

    // decision for the current request
    status_t             status_next;
    logic                ins_next;
    logic                del_next;
    logic                acc_next;
    logic                set_last_next;
    logic                hit;

    logic [SUM_W-1:0]    prod;
    logic [SUM_W:0]      wsum_wide;
    logic [TIME_W:0]     tsum_wide;
    logic [SUM_W-1:0]    wsum_next;
    logic [TIME_W-1:0]   tsum_next;

    // the chain is kept sorted by price, highest first, valid entries packed
    // at the front: cell 0 always holds the current maximum
    genvar gi;
    generate
        for (gi = 0; gi < BOOK_DEPTH; gi++)
        begin : g_cell
            entry_t prev_entry;
            entry_t next_entry;
            logic   prev_keep;
            logic   prev_gone;

            if (gi == 0)
            begin : g_head
                assign prev_entry = ENTRY_NONE;
                assign prev_keep  = 1'b1;
                assign prev_gone  = 1'b0;
            end
            else
            begin : g_body
                assign prev_entry = cell_q[gi-1];
                assign prev_keep  = keep_v[gi-1];
                assign prev_gone  = gone_v[gi-1];
            end

            if (gi == BOOK_DEPTH - 1)
            begin : g_tail
                assign next_entry = ENTRY_NONE;
            end
            else
            begin : g_link
                assign next_entry = cell_q[gi+1];
            end

            bmtws_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .req_key    (key_reg),
                .req_price  (price_reg),
                .prev_entry (prev_entry),
                .next_entry (next_entry),
                .prev_keep  (prev_keep),
                .prev_gone  (prev_gone),
                .entry      (cell_q[gi]),
                .keep       (keep_v[gi]),
                .match      (match_v[gi]),
                .gone       (gone_v[gi])
            );
        end
    endgenerate

    // product of elapsed time and the pre-update maximum; its inputs are
    // sampled during the decide cycle, so the result is ready in the accumulate cycle
    bmtws_mul u_mul (
        .clk   (clk),
        .dur   (dur_reg),
        .price (cell_q[0].price),
        .prod  (prod)
    );

    // request decision from the captured match and order flags
    always_comb
    begin
        hit           = |match_v;
        status_next   = STATUS_OK;
        ins_next      = 1'b0;
        del_next      = 1'b0;
        acc_next      = 1'b0;
        set_last_next = 1'b0;
        if (cmd_reg == CMD_INSERT)
        begin
            if (hit)
                status_next = STATUS_DUP;
            else if (cell_q[BOOK_DEPTH-1].valid)
                status_next = STATUS_FULL;
            else
            begin
                ins_next = 1'b1;
                // first order only starts the clock
                if (!cell_q[0].valid)
                    set_last_next = 1'b1;
                else
                    acc_next = !keep_v[0];  // new price strictly above the max
            end
        end
        else
        begin
            if (!hit)
                status_next = STATUS_MISS;
            else
            begin
                del_next = 1'b1;
                // only removing the head can lower the max
                acc_next = match_v[0] &&
                           (!cell_q[1].valid || (cell_q[0].price > cell_q[1].price));
            end
        end
    end

    always_comb
    begin
        ctrl.cmp = (state_reg == S_MATCH);
        ctrl.ins = (state_reg == S_DECIDE) && ins_next;
        ctrl.del = (state_reg == S_DECIDE) && del_next;
    end

    // saturating accumulators
    always_comb
    begin
        wsum_wide = {1'b0, wsum_reg} + {1'b0, prod};
        tsum_wide = {1'b0, tsum_reg} + {1'b0, dur_reg};
        wsum_next = wsum_wide[SUM_W] ? '1 : wsum_wide[SUM_W-1:0];
        tsum_next = tsum_wide[TIME_W] ? '1 : tsum_wide[TIME_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            status_reg   <= STATUS_OK;
            acc_reg      <= 1'b0;
            set_last_reg <= 1'b0;
            last_reg     <= '0;
            wsum_reg     <= '0;
            tsum_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                        state_reg <= S_MATCH;
                end
                S_MATCH:
                begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    status_reg   <= status_next;
                    acc_reg      <= acc_next;
                    set_last_reg <= set_last_next;
                    state_reg    <= S_MUL;
                end
                S_MUL:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (acc_reg)
                    begin
                        wsum_reg <= wsum_next;
                        tsum_reg <= tsum_next;
                        last_reg <= now_reg;
                    end
                    else if (set_last_reg)
                        last_reg <= now_reg;
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // request payload and elapsed time, no reset needed
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start)
        begin
            cmd_reg   <= cmd;
            now_reg   <= timestamp_ms;
            key_reg   <= order_id;
            price_reg <= order_price;
        end
        if (state_reg == S_MATCH)
        begin
            // an out-of-order timestamp counts as no elapsed time
            dur_reg <= (now_reg >= last_reg) ? (now_reg - last_reg) : '0;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign weighted_sum = wsum_reg;
    assign time_sum     = tsum_reg;
    assign best_price   = cell_q[0].valid ? cell_q[0].price : '0;
    assign book_empty   = !cell_q[0].valid;

endmodule

FILE: sv/bmtws_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmtws_chk
// port-level timing and result checks, bound to the top level
// ----------------------------------------------------------------------------
module bmtws_chk
    import bmtws_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               done,
    input  logic [1:0]         status,
    input  logic [SUM_W-1:0]   weighted_sum,
    input  logic [TIME_W-1:0]  time_sum,
    input  logic [PRICE_W-1:0] best_price,
    input  logic               book_empty
);

    // each accepted request must be followed by its result strobe
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##5 done)
        else $error("result strobe missing 5 cycles after request");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after request accepted");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_empty_price: assert property (@(posedge clk) disable iff (!rst_n)
        (done && book_empty) |-> (best_price == '0))
        else $error("empty book reports nonzero best price");

    // a rejected request must not move the sums
    a_reject_holds_sums: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != STATUS_OK)) |->
            ($stable(weighted_sum) && $stable(time_sum)))
        else $error("sums changed on a rejected request");

endmodule

bind book_max_time_weighted_sum bmtws_chk u_bmtws_chk (.*);
